FILE: hw/rtl/sha256_stream_hasher_defines.svh
// Assertion macros used by the hasher module.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SHS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/shs_pkg.sv
// Types, constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RDA   = 8'b0000_0010,
        S_RDB   = 8'b0000_0100,
        S_SCHED = 8'b0000_1000,
        S_ROUND = 8'b0001_0000,
        S_FOLD  = 8'b0010_0000,
        S_PAD   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

FILE: hw/rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher: takes one data byte per accepted item and returns
// the eight digest words of each message. Bytes are taken one per cycle while
// the hasher is idle; the 64th byte of a block starts a compression (rounds
// 0-15 pass through the read, schedule and round states, rounds 16-63 add a
// second read state, and a fold adds the result into the chain value), during
// which input is stalled. The round pace is set by the 16-word schedule RAM,
// whose two read ports fetch the four schedule taps of a round over the two
// read states. On a last item the padding is written one word per cycle, one
// or two compressions follow, and the digest leaves over 8 output words,
// index 0 first; input stays stalled until the eighth word is taken.
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher import shs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state, n_state;
    logic [60:0] r_cnt, n_cnt;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_oidx, n_oidx;
    logic [3:0]  r_widx, n_widx;
    logic        r_first, n_first;
    logic        r_tail, n_tail;
    logic        r_pad_pend, n_pad_pend;
    logic        r_fin, n_fin;
    logic [31:0] r_h [8];
    logic [31:0] n_h [8];
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [23:0] r_pack, n_pack;
    logic [31:0] r_w, n_w;
    logic [31:0] r_x16, n_x16;
    logic [31:0] r_x15, n_x15;

    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [3:0]  ram_raddr_a;
    logic [3:0]  ram_raddr_b;
    logic [31:0] ram_rdata_a;
    logic [31:0] ram_rdata_b;

    logic        in_acc;
    logic        out_acc;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] pad_word;

    shs_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_sched (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr_a(ram_raddr_a),
        .i_raddr_b(ram_raddr_b),
        .o_rdata_a(ram_rdata_a),
        .o_rdata_b(ram_rdata_b)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign out_acc = o_valid && !i_stall;

    // Round datapath on the working variables a..h.
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_sigma1(r_v[4]) + ch + ROUND_K[r_round] + r_w;
    assign t2  = big_sigma0(r_v[0]) + maj;

    // Word that holds the pad byte, merged with the bytes packed so far.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'd0};
            2'd1:    pad_word = {r_pack[23:16], PAD_BYTE, 16'd0};
            2'd2:    pad_word = {r_pack[23:8], PAD_BYTE, 8'd0};
            2'd3:    pad_word = {r_pack, PAD_BYTE};
            default: pad_word = {PAD_BYTE, 24'd0};
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_round    = r_round;
        n_oidx     = r_oidx;
        n_widx     = r_widx;
        n_first    = r_first;
        n_tail     = r_tail;
        n_pad_pend = r_pad_pend;
        n_fin      = r_fin;
        n_h        = r_h;
        n_v        = r_v;
        n_pack     = r_pack;
        n_w        = r_w;
        n_x16      = r_x16;
        n_x15      = r_x15;
        ram_we     = 1'b0;
        ram_waddr  = r_round[3:0];
        ram_wdata  = '0;
        ram_raddr_a = r_round[3:0];
        ram_raddr_b = r_round[3:0] + 4'd1;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_byte_valid) begin
                        case (r_cnt[1:0])
                            2'd0: n_pack = {i_data_byte, 16'd0};
                            2'd1: n_pack[15:8] = i_data_byte;
                            2'd2: n_pack[7:0] = i_data_byte;
                            2'd3: begin
                                ram_we    = 1'b1;
                                ram_waddr = r_cnt[5:2];
                                ram_wdata = {r_pack, i_data_byte};
                            end
                            default: n_pack = r_pack;
                        endcase
                        n_cnt = r_cnt + 61'd1;
                        if (r_cnt[5:0] == 6'd63) begin
                            // block full: compress, then pad if last
                            n_v        = r_h;
                            n_pad_pend = i_last;
                            n_first    = 1'b1;
                            n_fin      = 1'b0;
                            n_state    = S_RDA;
                        end else if (i_last) begin
                            n_first = 1'b1;
                            n_state = S_PAD;
                        end
                    end else if (i_last) begin
                        n_first = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_RDA: begin
                ram_raddr_a = r_round[3:0];
                ram_raddr_b = r_round[3:0] + 4'd1;
                n_state = (r_round[5:4] == 2'd0) ? S_SCHED : S_RDB;
            end
            S_RDB: begin
                n_x16       = ram_rdata_a;
                n_x15       = ram_rdata_b;
                ram_raddr_a = r_round[3:0] + 4'd9;
                ram_raddr_b = r_round[3:0] + 4'd14;
                n_state     = S_SCHED;
            end
            S_SCHED: begin
                if (r_round[5:4] == 2'd0) begin
                    n_w = ram_rdata_a;
                end else begin
                    n_w = r_x16 + small_sigma0(r_x15) + ram_rdata_a
                        + small_sigma1(ram_rdata_b);
                    ram_we    = 1'b1;
                    ram_waddr = r_round[3:0];
                    ram_wdata = n_w;
                end
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_v[0]  = t1 + t2;
                n_v[1]  = r_v[0];
                n_v[2]  = r_v[1];
                n_v[3]  = r_v[2];
                n_v[4]  = r_v[3] + t1;
                n_v[5]  = r_v[4];
                n_v[6]  = r_v[5];
                n_v[7]  = r_v[6];
                n_round = r_round + 6'd1;
                n_state = (r_round == 6'd63) ? S_FOLD : S_RDA;
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                if (r_fin) begin
                    n_oidx  = 3'd0;
                    n_state = S_OUT;
                end else if (r_pad_pend) begin
                    n_pad_pend = 1'b0;
                    n_state    = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PAD: begin
                ram_we = 1'b1;
                if (r_first) begin
                    ram_waddr = r_cnt[5:2];
                    ram_wdata = pad_word;
                    n_first   = 1'b0;
                    n_tail    = (r_cnt[5:3] != 3'b111);
                    n_widx    = r_cnt[5:2] + 4'd1;
                    if ((r_cnt[5:3] == 3'b111) && (r_cnt[5:2] == 4'd15)) begin
                        // pad byte closes the block: length goes in an extra one
                        n_v        = r_h;
                        n_pad_pend = 1'b1;
                        n_tail     = 1'b1;
                        n_widx     = 4'd0;
                        n_fin      = 1'b0;
                        n_state    = S_RDA;
                    end
                end else begin
                    ram_waddr = r_widx;
                    if (r_tail && (r_widx == 4'd14)) begin
                        ram_wdata = r_cnt[60:29];
                    end else if (r_tail && (r_widx == 4'd15)) begin
                        ram_wdata = {r_cnt[28:0], 3'b000};
                    end else begin
                        ram_wdata = '0;
                    end
                    n_widx = r_widx + 4'd1;
                    if (r_widx == 4'd15) begin
                        n_v = r_h;
                        if (r_tail) begin
                            n_fin      = 1'b1;
                            n_pad_pend = 1'b0;
                        end else begin
                            n_fin      = 1'b0;
                            n_pad_pend = 1'b1;
                            n_tail     = 1'b1;
                            n_widx     = 4'd0;
                        end
                        n_state = S_RDA;
                    end
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        // digest gone: start a fresh message
                        n_h     = HASH_INIT;
                        n_cnt   = '0;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_round    <= '0;
            r_oidx     <= '0;
            r_widx     <= '0;
            r_first    <= 1'b0;
            r_tail     <= 1'b0;
            r_pad_pend <= 1'b0;
            r_fin      <= 1'b0;
            r_h        <= HASH_INIT;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_round    <= n_round;
            r_oidx     <= n_oidx;
            r_widx     <= n_widx;
            r_first    <= n_first;
            r_tail     <= n_tail;
            r_pad_pend <= n_pad_pend;
            r_fin      <= n_fin;
            r_h        <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_pack <= n_pack;
        r_w    <= n_w;
        r_x16  <= n_x16;
        r_x15  <= n_x15;
    end

    `SHS_ASSERT(a_out_blocks_in, o_valid |-> o_stall, "input open while digest is out")
    `SHS_ASSERT(a_word_order,
        (o_valid && !i_stall && !o_last_word) |=>
            (o_valid && (o_word_index == $past(o_word_index) + 3'd1)),
        "digest words out of order")
    `SHS_ASSERT(a_round_idle, (r_state == S_IDLE) |-> (r_round == 6'd0),
        "round counter not at zero between items")
    `SHS_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

FILE: hw/rtl/shs_ram.sv
// Generic RAM: one write port, two registered read ports.
module shs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
